// ===== rtl/tpce_pkg.sv =====
// Shared types, constants and helper functions of the typed prefix code encoder.
package tpce_pkg;

    localparam int NUM_CODES = 8;
    localparam int ENTRY_W   = 62;
    localparam int CFG_IDX_W = 3;
    localparam int Q_W       = 26;   // floor(2^32 / 100) fits in 26 bits

    // operations
    localparam logic [1:0] OP_SIGNED   = 2'd0;
    localparam logic [1:0] OP_UNSIGNED = 2'd1;
    localparam logic [1:0] OP_FLUSH    = 2'd2;
    localparam logic [1:0] OP_NOP      = 2'd3;

    // entry kinds
    localparam logic [2:0] K_CONST  = 3'd1;
    localparam logic [2:0] K_UNS    = 3'd2;
    localparam logic [2:0] K_SGN    = 3'd3;
    localparam logic [2:0] K_HUNS   = 3'd4;
    localparam logic [2:0] K_HSGN   = 3'd5;
    localparam logic [2:0] K_ORIG   = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_WIDE    = 2'd2;

    // x / 100 == (x * RECIP_100) >> 37 for every 32-bit x
    localparam logic [31:0] RECIP_100 = 32'h51EB_851F;
    localparam logic [31:0] HUNDRED   = 32'd100;

    typedef logic [ENTRY_W-1:0] t_entry;

    typedef struct packed {
        logic        valid;
        logic [1:0]  op;
        logic        pos;
        logic [31:0] raw;
        logic [31:0] dw;
    } t_carry;

    typedef struct packed {
        logic        valid;
        logic [1:0]  op;
        logic [48:0] bits;
        logic [5:0]  nbits;
        logic [1:0]  status;
        logic [2:0]  index;
        logic [5:0]  coded;
    } t_item;

    function automatic logic [5:0] dlen_of(input t_entry e);
        return (e[8:3] > 6'd32) ? 6'd32 : e[8:3];
    endfunction

    function automatic logic [4:0] clen_of(input t_entry e);
        return (e[13:9] > 5'd16) ? 5'd16 : e[13:9];
    endfunction

    function automatic logic fit_u(input logic [31:0] s, input logic [5:0] len);
        return (len >= 6'd32) || ((s >> len) == 32'd0);
    endfunction

    function automatic logic fit_s(input logic neg, input logic [31:0] s,
                                   input logic [5:0] len);
        logic [5:0] sh;
        sh = len - 6'd1;
        if (len == 6'd0) begin
            return 1'b0;
        end
        if (neg) begin
            return (s >> sh) == (32'hFFFF_FFFF >> sh);
        end
        return (s >> sh) == 32'd0;
    endfunction

endpackage

// ===== rtl/typed_prefix_code_encoder_unit.sv =====
// Top level of the typed prefix code encoder: ports, input register, stage wiring.
//
// Input stream (s_axis): one item per value to code, or a flush. tuser carries the
// operation (signed encode, unsigned encode, flush or no-op); tdata carries value, base,
// use_base and reverse. Output stream (m_axis): one item per finished byte, with
// tlast on the final item of each input; an input that finishes no byte gives one
// item with tuser (byte valid) low. Status, entry index and coded length repeat on
// every output item of an input.
// The code table is eight 62-bit entries written through i_cfg_we / i_cfg_index /
// i_cfg_data; write it only while no item is in flight.
// Stages: input register, four front stages, match, build, byte emitter. Throughput:
// an input item enters every cycle while the emitter keeps up; the emitter sends one
// byte per cycle while the receiver is ready, and an input gives 1 to 7 output items.
// Reset clears the table, the pending bits and all valid flags. When the receiver
// stalls, the output register holds and the emitter waits; the whole pipe halts and
// tready drops as soon as a built item has to wait for the emitter.
module typed_prefix_code_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // value[31:0], base[63:32], use_base[64],
                                         // reverse[65], zero[71:66]
    input  logic [1:0]  i_s_axis_tuser,  // operation[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // out_byte[7:0], status[9:8],
                                         // entry_index[12:10], bits_coded[18:13], zero
    output logic        o_m_axis_tuser,  // byte_valid
    output logic        o_m_axis_tlast,  // last
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [61:0] i_cfg_data
);

    logic        r_v;
    logic [1:0]  r_op;
    logic [31:0] r_value, r_base;
    logic        r_use, r_rev;
    logic        en, pack_ready;

    tpce_pkg::t_carry carry;
    tpce_pkg::t_item  item;
    logic [31:0] q4, q5s;
    logic        z4, z5;
    logic [7:0]  ob;
    logic [1:0]  ost;
    logic [2:0]  oidx;
    logic [5:0]  ocod;

    // whole pipe advances together when the emitter can take the built item
    assign en              = !item.valid || pack_ready;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op    <= i_s_axis_tuser;
            r_value <= i_s_axis_tdata[31:0];
            r_base  <= i_s_axis_tdata[63:32];
            r_use   <= i_s_axis_tdata[64];
            r_rev   <= i_s_axis_tdata[65];
        end
    end

    tpce_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_v),
        .i_op       (r_op),
        .i_value    (r_value),
        .i_base     (r_base),
        .i_use_base (r_use),
        .i_reverse  (r_rev),
        .o_carry    (carry),
        .o_q4       (q4),
        .o_q5s      (q5s),
        .o_z4       (z4),
        .o_z5       (z5)
    );

    tpce_match u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_carry     (carry),
        .i_q4        (q4),
        .i_q5s       (q5s),
        .i_z4        (z4),
        .i_z5        (z5),
        .o_item      (item)
    );

    tpce_pack u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .o_ready      (pack_ready),
        .o_tvalid     (o_m_axis_tvalid),
        .i_tready     (i_m_axis_tready),
        .o_byte       (ob),
        .o_byte_valid (o_m_axis_tuser),
        .o_last       (o_m_axis_tlast),
        .o_status     (ost),
        .o_index      (oidx),
        .o_coded      (ocod)
    );

    assign o_m_axis_tdata = {5'd0, ocod, oidx, ost, ob};

endmodule

// ===== rtl/tpce_prep.sv =====
// Front stages: sign handling, delta against base, and division by 100.
module tpce_prep (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [1:0]             i_op,
    input  logic [31:0]            i_value,
    input  logic [31:0]            i_base,
    input  logic                   i_use_base,
    input  logic                   i_reverse,
    output tpce_pkg::t_carry       o_carry,
    output logic [31:0]            o_q4,
    output logic [31:0]            o_q5s,
    output logic                   o_z4,
    output logic                   o_z5
);

    tpce_pkg::t_carry n_c1;
    tpce_pkg::t_carry r_c1, r_c2, r_c3, r_c4;
    logic [31:0] r_mag, r_x5;
    logic [tpce_pkg::Q_W-1:0] r_q4, r_q5;
    logic [63:0] p4, p5;
    logic [31:0] rem4, rem5, q4_ext, q5_ext;
    logic [31:0] r_q4o, r_q5s;
    logic        r_z4, r_z5;
    logic        pos;
    logic [31:0] raw, bse;
    logic        rev;

    always_comb begin
        pos = !i_value[31] && (i_value != 32'd0);
        raw = i_value;
        bse = i_base;
        rev = i_reverse;
        if (i_op == tpce_pkg::OP_SIGNED) begin
            if (!pos) begin
                raw = 32'd0 - i_value;
                bse = 32'd0 - i_base;
            end
            rev = 1'b0;
        end
        n_c1.valid = i_valid;
        n_c1.op    = i_op;
        n_c1.pos   = pos;
        n_c1.raw   = raw;
        n_c1.dw    = raw;
        if (i_use_base) begin
            n_c1.dw = rev ? (bse - raw) : (raw - bse);
        end
    end

    assign p4 = {32'd0, r_c2.dw} * {32'd0, tpce_pkg::RECIP_100};
    assign p5 = {32'd0, r_mag} * {32'd0, tpce_pkg::RECIP_100};

    assign q4_ext = {{(32-tpce_pkg::Q_W){1'b0}}, r_q4};
    assign q5_ext = {{(32-tpce_pkg::Q_W){1'b0}}, r_q5};
    assign rem4   = r_c3.dw - q4_ext * tpce_pkg::HUNDRED;
    assign rem5   = r_x5 - q5_ext * tpce_pkg::HUNDRED;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
        end else if (i_en) begin
            r_c1 <= n_c1;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
            r_c4 <= r_c3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= r_c1.dw[31] ? (32'd0 - r_c1.dw) : r_c1.dw;
            r_x5  <= r_mag;
            r_q4  <= p4[37+tpce_pkg::Q_W-1:37];
            r_q5  <= p5[37+tpce_pkg::Q_W-1:37];
            r_z4  <= (rem4 == 32'd0);
            r_z5  <= (rem5 == 32'd0);
            r_q4o <= q4_ext;
            r_q5s <= r_c3.dw[31] ? (32'd0 - q5_ext) : q5_ext;
        end
    end

    assign o_carry = r_c4;
    assign o_q4    = r_q4o;
    assign o_q5s   = r_q5s;
    assign o_z4    = r_z4;
    assign o_z5    = r_z5;

endmodule

// ===== rtl/tpce_match.sv =====
// Code table, per-entry match, first-hit select and code word build.
module tpce_match (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_cfg_we,
    input  logic [tpce_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  tpce_pkg::t_entry              i_cfg_data,
    input  tpce_pkg::t_carry              i_carry,
    input  logic [31:0]                   i_q4,
    input  logic [31:0]                   i_q5s,
    input  logic                          i_z4,
    input  logic                          i_z5,
    output tpce_pkg::t_item               o_item
);

    tpce_pkg::t_entry r_tab [tpce_pkg::NUM_CODES];
    logic [tpce_pkg::NUM_CODES-1:0] n_hit, r_hit;
    logic [31:0] n_s [tpce_pkg::NUM_CODES];
    logic [31:0] r_s [tpce_pkg::NUM_CODES];
    tpce_pkg::t_carry r_c5;
    tpce_pkg::t_item  n_item, r_item;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < tpce_pkg::NUM_CODES; i++) begin
            if (!i_rst_n) begin
                r_tab[i] <= '0;
            end else if (i_cfg_we && i_cfg_index == tpce_pkg::CFG_IDX_W'(i)) begin
                r_tab[i] <= i_cfg_data;
            end
        end
    end

    // one matcher per entry
    always_comb begin
        for (int i = 0; i < tpce_pkg::NUM_CODES; i++) begin
            logic [5:0]  dl;
            logic [31:0] b, v, s;
            logic        neg, h;
            dl  = tpce_pkg::dlen_of(r_tab[i]);
            b   = r_tab[i][61:30];
            v   = i_carry.dw;
            neg = v[31];
            s   = v;
            h   = 1'b0;
            unique case (r_tab[i][2:0])
                tpce_pkg::K_CONST: begin
                    h = (v == b);
                end
                tpce_pkg::K_UNS: begin
                    s = v - b;
                    h = tpce_pkg::fit_u(s, dl);
                end
                tpce_pkg::K_SGN: begin
                    s = neg ? (v + b) : (v - b);
                    h = tpce_pkg::fit_s(neg, s, dl);
                end
                tpce_pkg::K_HUNS: begin
                    s = i_q4 - b;
                    h = i_z4 && tpce_pkg::fit_u(s, dl);
                end
                tpce_pkg::K_HSGN: begin
                    s = neg ? (i_q5s + b) : (i_q5s - b);
                    h = i_z5 && tpce_pkg::fit_s(neg, s, dl);
                end
                tpce_pkg::K_ORIG: begin
                    h = 1'b1;
                end
                default: begin
                    h = 1'b0;
                end
            endcase
            n_hit[i] = h;
            n_s[i]   = s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c5 <= '0;
        end else if (i_en) begin
            r_c5 <= i_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= n_hit;
            for (int i = 0; i < tpce_pkg::NUM_CODES; i++) begin
                r_s[i] <= n_s[i];
            end
        end
    end

    always_comb begin
        logic [2:0]  sel;
        logic        found, wide, ok, sign;
        tpce_pkg::t_entry e;
        logic [5:0]  dl, len, slen;
        logic [4:0]  cl;
        logic [31:0] data;
        logic [32:0] dmask;
        logic [16:0] cmask;
        logic [47:0] word;
        sel   = 3'd0;
        found = 1'b0;
        for (int i = tpce_pkg::NUM_CODES - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                sel   = 3'(i);
                found = 1'b1;
            end
        end
        e     = r_tab[sel];
        dl    = tpce_pkg::dlen_of(e);
        cl    = tpce_pkg::clen_of(e);
        wide  = (e[2:0] == tpce_pkg::K_ORIG) &&
                ((dl == 6'd0) || ((dl < 6'd32) && ((r_c5.raw >> dl) != 32'd0)));
        ok    = found && !wide;
        data  = (e[2:0] == tpce_pkg::K_ORIG) ? r_c5.raw : r_s[sel];
        dmask = (33'd1 << dl) - 33'd1;
        cmask = (17'd1 << cl) - 17'd1;
        word  = ({32'd0, e[29:14] & cmask[15:0]} << dl) | {16'd0, data & dmask[31:0]};
        len   = {1'b0, cl} + dl;
        slen  = ok ? len : 6'd0;
        sign  = (r_c5.op == tpce_pkg::OP_SIGNED);

        n_item.valid  = r_c5.valid;
        n_item.op     = r_c5.op;
        n_item.bits   = '0;
        n_item.nbits  = 6'd0;
        n_item.status = tpce_pkg::ST_OK;
        n_item.index  = 3'd0;
        n_item.coded  = 6'd0;
        if (r_c5.op == tpce_pkg::OP_SIGNED || r_c5.op == tpce_pkg::OP_UNSIGNED) begin
            n_item.bits   = (ok ? {1'b0, word} : 49'd0) |
                            ({48'd0, sign & r_c5.pos} << slen);
            n_item.nbits  = {5'd0, sign} + slen;
            n_item.status = !found ? tpce_pkg::ST_NOMATCH :
                            (wide ? tpce_pkg::ST_WIDE : tpce_pkg::ST_OK);
            n_item.index  = sel;
            n_item.coded  = slen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= '0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== rtl/tpce_pack.sv =====
// Bit accumulator: merges code words with pending bits and emits one byte per cycle while the receiver is ready.
module tpce_pack (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tpce_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [7:0]      o_byte,
    output logic            o_byte_valid,
    output logic            o_last,
    output logic [1:0]      o_status,
    output logic [2:0]      o_index,
    output logic [5:0]      o_coded
);

    logic        r_busy, r_empty;
    logic [55:0] r_acc;
    logic [5:0]  r_n;
    logic [1:0]  r_status;
    logic [2:0]  r_index;
    logic [5:0]  r_coded;
    logic        r_ov, r_obv, r_olast;
    logic [7:0]  r_ob;
    logic [1:0]  r_ost;
    logic [2:0]  r_oidx;
    logic [5:0]  r_ocod;

    logic        slot, emit, is_last, load;
    logic [5:0]  n_after, base_n;
    logic [2:0]  pcnt;
    logic [55:0] n_acc;
    logic [5:0]  n_n;
    logic        n_empty;
    logic [7:0]  cur_byte;

    assign slot     = !r_ov || i_tready;
    assign emit     = r_busy && slot;
    assign is_last  = r_empty || (r_n < 6'd16);
    assign n_after  = r_empty ? r_n : (r_n - 6'd8);
    assign o_ready  = !r_busy || (emit && is_last);
    assign load     = i_item.valid && o_ready;
    assign base_n   = emit ? n_after : r_n;
    assign pcnt     = base_n[2:0];
    assign cur_byte = 8'(r_acc >> (r_n - 6'd8));

    always_comb begin
        n_acc   = r_acc;
        n_n     = base_n;
        n_empty = 1'b1;
        unique case (i_item.op)
            tpce_pkg::OP_SIGNED, tpce_pkg::OP_UNSIGNED: begin
                n_acc   = (r_acc << i_item.nbits) | {7'd0, i_item.bits};
                n_n     = base_n + i_item.nbits;
                n_empty = (n_n < 6'd8);
            end
            tpce_pkg::OP_FLUSH: begin
                // pad the pending bits up to a whole byte
                if (pcnt != 3'd0) begin
                    n_acc   = r_acc << (4'd8 - {1'b0, pcnt});
                    n_n     = 6'd8;
                    n_empty = 1'b0;
                end
            end
            default: begin
                n_empty = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_n    <= 6'd0;
            r_acc  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_acc  <= n_acc;
            r_n    <= n_n;
        end else if (emit) begin
            r_n <= n_after;
            if (is_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_empty  <= n_empty;
            r_status <= i_item.status;
            r_index  <= i_item.index;
            r_coded  <= i_item.coded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (i_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ob    <= r_empty ? 8'd0 : cur_byte;
            r_obv   <= !r_empty;
            r_olast <= is_last;
            r_ost   <= r_status;
            r_oidx  <= r_index;
            r_ocod  <= r_coded;
        end
    end

    assign o_tvalid     = r_ov;
    assign o_byte       = r_ob;
    assign o_byte_valid = r_obv;
    assign o_last       = r_olast;
    assign o_status     = r_ost;
    assign o_index      = r_oidx;
    assign o_coded      = r_ocod;

endmodule
